// ===== rtl/ptpl_pkg.sv =====
`timescale 1ns / 1ps

package ptpl_pkg;

    localparam int POS_W      = 16;
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 8;
    localparam int CFG_INDEX_W = 1;

    // Length scale 0.2482 cm per (100 ms)^2, kept as 2482 / 10^8 per ms^2.
    localparam int LEN_NUM_W  = 12;
    localparam logic [LEN_NUM_W-1:0] LEN_NUM = 12'd2482;
    localparam int DEN_W      = 27;
    localparam logic [DEN_W-1:0] LEN_DEN = 27'd100000000;

    // d is at most 16 bits, d*d fits 32 bits, times 2482 fits 44 bits.
    localparam int DIFF_W     = 16;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ACC_W      = SQ_W + LEN_NUM_W;
    localparam int FRAC_W     = 8;

    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TURN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LENGTH = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SQ,
        ST_MUL_K,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/pendulum_turn_period_length_top.sv =====
`timescale 1ns / 1ps

// Pendulum turn detector and length estimator.
// The input stream carries one word per camera frame: three recent blob x
// positions and the frame's millisecond tick. A falling run arms the detector
// and a following rising run completes a turn. On every turn after the first,
// the tick difference d since the previous turn gives the length
// 0.2482 * (d/100)^2 cm, which is kept when it lies between the two length
// registers. Every input word produces exactly one output word with the
// status, the currently stored length (Q8 cm) and the turn count.
// A word without a new length computation goes straight to the output register.
// A turn with a valid earlier turn time and d below 65536 first squares d and
// then scales by 2482 on one bit-serial shift-add unit, then runs a restoring
// divider by 10^8, the range check and the load of the output register.
// The block works on one word at a time; s_tready is high only while idle.
// The output register holds a finished word while the receiver stalls, and
// a new input word is taken meanwhile; a second result waits until the
// output register frees up.
// Reset clears the detector, the turn count, the stored length and the
// earlier-turn flag, and loads 20 cm and 180 cm into the length limits.
// Configuration writes take effect at once and are meant for idle periods.
module pendulum_turn_period_length_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: position_newest, position_middle, position_oldest, capture_time
    input  logic [79:0]                         s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: length_q8, turn_count
    output logic [31:0]                         m_tdata,
    // m_tuser: status
    output logic [ptpl_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [ptpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptpl_pkg::CFG_W-1:0]          cfg_wdata
);
    import ptpl_pkg::*;

    state_t                 state_reg, state_next;
    logic                   armed_reg, armed_next;
    logic                   prev_valid_reg, prev_valid_next;
    logic [TIME_W-1:0]      prev_time_reg, prev_time_next;
    logic [LEN_W-1:0]       stored_length_reg, stored_length_next;
    logic [COUNT_W-1:0]     turns_seen_reg, turns_seen_next;
    logic [CFG_W-1:0]       min_len_reg, max_len_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // Shared bit-serial multiplier and divider datapath.
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [SQ_W-1:0]        mcand_reg, mcand_next;
    logic [DIFF_W-1:0]      mplr_reg, mplr_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [DEN_W-1:0]       rem_reg, rem_next;
    logic [DIFF_W-1:0]      nbits_reg, nbits_next;
    logic [LEN_W-1:0]       quo_reg, quo_next;
    logic                   ovf_reg, ovf_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [POS_W-1:0]       p0, p1, p2;
    logic [TIME_W-1:0]      now, diff;
    logic                   falling, rising, accept, out_free;
    logic [ACC_W-1:0]       step_sum;
    logic [DEN_W:0]         trial;
    logic                   trial_ge;
    logic [LEN_W-1:0]       min_q8, max_q8;
    logic                   in_range;

    assign p0  = s_tdata[15:0];
    assign p1  = s_tdata[31:16];
    assign p2  = s_tdata[47:32];
    assign now = s_tdata[79:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign falling  = (p0 > p1) && (p1 > p2);
    assign rising   = (p0 < p1) && (p1 < p2);
    assign diff     = now - prev_time_reg;

    // One shift-add step, multiplier bits taken from the top down.
    assign step_sum = {acc_reg[ACC_W-2:0], 1'b0}
                    + (mplr_reg[DIFF_W-1] ? {{LEN_NUM_W{1'b0}}, mcand_reg} : '0);

    // One restoring division step.
    assign trial    = {rem_reg, nbits_reg[DIFF_W-1]};
    assign trial_ge = (trial >= {1'b0, LEN_DEN});

    // floor(x) >= k iff x >= k; x <= k iff floor(x) < k or x is exactly k.
    assign min_q8   = {min_len_reg, {FRAC_W{1'b0}}};
    assign max_q8   = {max_len_reg, {FRAC_W{1'b0}}};
    assign in_range = !ovf_reg && (quo_reg >= min_q8)
                    && ((quo_reg < max_q8) || ((quo_reg == max_q8) && (rem_reg == '0)));

    always_comb begin
        state_next         = state_reg;
        armed_next         = armed_reg;
        prev_valid_next    = prev_valid_reg;
        prev_time_next     = prev_time_reg;
        stored_length_next = stored_length_reg;
        turns_seen_next    = turns_seen_reg;
        status_next        = status_reg;
        acc_next           = acc_reg;
        mcand_next         = mcand_reg;
        mplr_next          = mplr_reg;
        cnt_next           = cnt_reg;
        rem_next           = rem_reg;
        nbits_next         = nbits_reg;
        quo_next           = quo_reg;
        ovf_next           = ovf_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next  = ST_DONE;
                    status_next = STATUS_NONE;
                    if (!armed_reg) begin
                        armed_next = falling;
                    end else if (rising) begin
                        armed_next      = 1'b0;
                        turns_seen_next = turns_seen_reg + COUNT_W'(1);
                        status_next     = STATUS_TURN;
                        prev_time_next  = now;
                        prev_valid_next = 1'b1;
                        if (prev_valid_reg && (diff[TIME_W-1:DIFF_W] == '0)) begin
                            state_next = ST_MUL_SQ;
                            acc_next   = '0;
                            mcand_next = {{(SQ_W-DIFF_W){1'b0}}, diff[DIFF_W-1:0]};
                            mplr_next  = diff[DIFF_W-1:0];
                            cnt_next   = 4'(DIFF_W - 1);
                        end
                    end
                end
            end
            ST_MUL_SQ: begin
                acc_next  = step_sum;
                mplr_next = {mplr_reg[DIFF_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_MUL_K;
                    acc_next   = '0;
                    mcand_next = step_sum[SQ_W-1:0];
                    mplr_next  = {LEN_NUM, {(DIFF_W-LEN_NUM_W){1'b0}}};
                    cnt_next   = 4'(LEN_NUM_W - 1);
                end
            end
            ST_MUL_K: begin
                acc_next  = step_sum;
                mplr_next = {mplr_reg[DIFF_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    // Numerator is the scaled square shifted left by eight.
                    state_next = ST_DIV;
                    ovf_next   = (step_sum[ACC_W-1:FRAC_W] >= {{(ACC_W-FRAC_W-DEN_W){1'b0}},
                                                              LEN_DEN});
                    rem_next   = step_sum[FRAC_W+DEN_W-1:FRAC_W];
                    nbits_next = {step_sum[FRAC_W-1:0], {FRAC_W{1'b0}}};
                    quo_next   = '0;
                    cnt_next   = 4'(LEN_W - 1);
                end
            end
            ST_DIV: begin
                rem_next   = trial_ge ? DEN_W'(trial - {1'b0, LEN_DEN}) : trial[DEN_W-1:0];
                quo_next   = {quo_reg[LEN_W-2:0], trial_ge};
                nbits_next = {nbits_reg[DIFF_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_DONE;
                if (in_range) begin
                    stored_length_next = quo_reg;
                    status_next        = STATUS_LENGTH;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {turns_seen_reg, stored_length_reg};
                    m_tuser_next  = status_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            armed_reg         <= 1'b0;
            prev_valid_reg    <= 1'b0;
            prev_time_reg     <= '0;
            stored_length_reg <= '0;
            turns_seen_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            armed_reg         <= armed_next;
            prev_valid_reg    <= prev_valid_next;
            prev_time_reg     <= prev_time_next;
            stored_length_reg <= stored_length_next;
            turns_seen_reg    <= turns_seen_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= 8'd20;
            max_len_reg <= 8'd180;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MIN_LENGTH: min_len_reg <= cfg_wdata;
                CFG_MAX_LENGTH: max_len_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplr_reg    <= mplr_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        nbits_reg   <= nbits_next;
        quo_reg     <= quo_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The stored length only changes in the range-check cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CHECK) |=> $stable(stored_length_reg))
        else $error("stored length changed outside the range check");

    // The turn counter only moves when an input word is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(turns_seen_reg))
        else $error("turn counter changed without an input word");

    // A finished result waits while the output register is still occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result left while the output register was full");

    // A new length is reported only when the range check passed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && !in_range) |=> (status_reg == STATUS_TURN))
        else $error("length status without a passing range check");

endmodule
